// ===== src/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the crossover detector blocks.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent implication checked on every rising clk edge, off while in reset.
`define SMAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Trigger this cycle, property in the next cycle.
`define SMAC_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) trig |=> prop) \
        else $error(msg);

`endif

// ===== src/smac_pkg.sv =====
// ---------------------------------------------------------------------------
// smac_pkg
// Shared types and constants for the moving average crossover detector.
// ---------------------------------------------------------------------------
package smac_pkg;

    localparam int MAX_WINDOW_DEF = 256;
    localparam int PRICE_BITS_DEF = 32;

    localparam int SHORT_W    = 8;
    localparam int LONG_W     = 9;
    localparam int CFG_DATA_W = 9;
    localparam int PRICE_IN_W = 32;

    localparam logic [SHORT_W-1:0] SHORT_RST = 8'd5;
    localparam logic [LONG_W-1:0]  LONG_RST  = 9'd20;

    typedef enum logic [0:0] {
        REG_SHORT = 1'b0,
        REG_LONG  = 1'b1
    } reg_idx_t;

    typedef enum logic [1:0] {
        REL_EQUAL = 2'd0,
        REL_BELOW = 2'd1,
        REL_ABOVE = 2'd2
    } rel_t;

    typedef enum logic [1:0] {
        SIG_NONE = 2'd0,
        SIG_BUY  = 2'd1,
        SIG_SELL = 2'd2
    } sig_t;

    // per-bar control that travels down the pipe
    typedef struct packed {
        logic               bad;
        logic               warm;
        logic               drop_short;
        logic               drop_long;
        logic [SHORT_W-1:0] short_count;
        logic [LONG_W-1:0]  long_count;
    } bar_ctl_t;

endpackage

// ===== src/smac_window.sv =====
// ---------------------------------------------------------------------------
// smac_window
// Input stage: price ring, write slot and bar count, reads of the two bars
// that leave the windows.
// ---------------------------------------------------------------------------
module smac_window #(
    parameter int MAX_WINDOW = smac_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = smac_pkg::PRICE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic [smac_pkg::SHORT_W-1:0]      short_len,
    input  logic [smac_pkg::LONG_W-1:0]       long_len,
    input  logic                              bad,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [PRICE_BITS-1:0]             price,
    output logic                              s1_valid,
    input  logic                              s1_ready,
    output smac_pkg::bar_ctl_t                s1_ctl,
    output logic [PRICE_BITS-1:0]             s1_price,
    output logic [PRICE_BITS-1:0]             s1_old_short,
    output logic [PRICE_BITS-1:0]             s1_old_long
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int DW = ((AW > smac_pkg::LONG_W) ? AW : smac_pkg::LONG_W) + 1;

    logic [PRICE_BITS-1:0] ring_mem [MAX_WINDOW];

    logic [AW-1:0]                 write_slot_reg;
    logic [smac_pkg::LONG_W-1:0]   bars_seen_reg;
    logic [smac_pkg::LONG_W-1:0]   bars_next;
    logic                          s1_valid_reg;
    smac_pkg::bar_ctl_t            s1_ctl_reg;
    smac_pkg::bar_ctl_t            ctl_next;
    logic [PRICE_BITS-1:0]         s1_price_reg;
    logic [PRICE_BITS-1:0]         s1_old_short_reg;
    logic [PRICE_BITS-1:0]         s1_old_long_reg;
    logic [DW-1:0]                 short_diff;
    logic [DW-1:0]                 long_diff;
    logic                          accept;

    assign in_ready = !s1_valid_reg || s1_ready;
    assign accept   = in_valid && in_ready;

    // slot that is w bars back from the write slot, modulo ring depth
    always_comb
    begin
        short_diff = DW'(write_slot_reg) - DW'(short_len);
        if (short_diff[DW-1])
        begin
            short_diff = short_diff + DW'(MAX_WINDOW);
        end
        long_diff = DW'(write_slot_reg) - DW'(long_len);
        if (long_diff[DW-1])
        begin
            long_diff = long_diff + DW'(MAX_WINDOW);
        end
    end

    always_comb
    begin
        bars_next = (bars_seen_reg < long_len) ? bars_seen_reg + 1'b1 : bars_seen_reg;
        ctl_next.bad         = bad;
        ctl_next.warm        = (bars_next >= long_len);
        ctl_next.drop_short  = (bars_seen_reg >= {1'b0, short_len});
        ctl_next.drop_long   = (bars_seen_reg >= long_len);
        ctl_next.short_count = (bars_next < {1'b0, short_len}) ?
                               bars_next[smac_pkg::SHORT_W-1:0] : short_len;
        ctl_next.long_count  = bars_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_slot_reg <= '0;
            bars_seen_reg  <= '0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (clear)
            begin
                write_slot_reg <= '0;
                bars_seen_reg  <= '0;
            end
            else if (accept && !bad)
            begin
                write_slot_reg <= (write_slot_reg == AW'(MAX_WINDOW - 1)) ?
                                  '0 : write_slot_reg + 1'b1;
                bars_seen_reg  <= bars_next;
            end
        end
    end

    // read-before-write: a bar leaving a full-depth window is read as it is replaced
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_old_short_reg <= ring_mem[short_diff[AW-1:0]];
            s1_old_long_reg  <= ring_mem[long_diff[AW-1:0]];
            s1_price_reg     <= price;
            s1_ctl_reg       <= ctl_next;
            if (!bad)
            begin
                ring_mem[write_slot_reg] <= price;
            end
        end
    end

    assign s1_valid     = s1_valid_reg;
    assign s1_ctl       = s1_ctl_reg;
    assign s1_price     = s1_price_reg;
    assign s1_old_short = s1_old_short_reg;
    assign s1_old_long  = s1_old_long_reg;

endmodule

// ===== src/smac_sums.sv =====
// ---------------------------------------------------------------------------
// smac_sums
// Running totals of the short and long windows, one bar per cycle while the next stage is ready.
// ---------------------------------------------------------------------------
module smac_sums #(
    parameter int MAX_WINDOW = smac_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = smac_pkg::PRICE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic                              s1_valid,
    output logic                              s1_ready,
    input  smac_pkg::bar_ctl_t                s1_ctl,
    input  logic [PRICE_BITS-1:0]             s1_price,
    input  logic [PRICE_BITS-1:0]             s1_old_short,
    input  logic [PRICE_BITS-1:0]             s1_old_long,
    output logic                              s2_valid,
    input  logic                              s2_ready,
    output smac_pkg::bar_ctl_t                s2_ctl,
    output logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0] short_total,
    output logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0] long_total
);

    localparam int TW = PRICE_BITS + $clog2(MAX_WINDOW);

    logic              s2_valid_reg;
    smac_pkg::bar_ctl_t s2_ctl_reg;
    logic [TW-1:0]     short_total_reg;
    logic [TW-1:0]     long_total_reg;
    logic [TW-1:0]     short_total_next;
    logic [TW-1:0]     long_total_next;
    logic              take;

    assign s1_ready = !s2_valid_reg || s2_ready;
    assign take     = s1_valid && s1_ready;

    always_comb
    begin
        short_total_next = short_total_reg + TW'(s1_price)
                         - (s1_ctl.drop_short ? TW'(s1_old_short) : '0);
        long_total_next  = long_total_reg + TW'(s1_price)
                         - (s1_ctl.drop_long ? TW'(s1_old_long) : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg    <= 1'b0;
            short_total_reg <= '0;
            long_total_reg  <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s2_valid_reg <= s1_valid;
            end
            if (clear)
            begin
                short_total_reg <= '0;
                long_total_reg  <= '0;
            end
            else if (take && !s1_ctl.bad)
            begin
                short_total_reg <= short_total_next;
                long_total_reg  <= long_total_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s2_ctl_reg <= s1_ctl;
        end
    end

    assign s2_valid    = s2_valid_reg;
    assign s2_ctl      = s2_ctl_reg;
    assign short_total = short_total_reg;
    assign long_total  = long_total_reg;

endmodule

// ===== src/smac_cross.sv =====
// ---------------------------------------------------------------------------
// smac_cross
// Cross-multiplied comparison of the averages, crossover decision and
// result register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module smac_cross #(
    parameter int MAX_WINDOW = smac_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = smac_pkg::PRICE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              clear,
    input  logic                              s2_valid,
    output logic                              s2_ready,
    input  smac_pkg::bar_ctl_t                s2_ctl,
    input  logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0] short_total,
    input  logic [PRICE_BITS+$clog2(MAX_WINDOW)-1:0] long_total,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [1:0]                        signal,
    output logic                              in_position,
    output logic                              warmed_up,
    output logic                              config_error
);

    localparam int TW = PRICE_BITS + $clog2(MAX_WINDOW);
    localparam int PW = TW + smac_pkg::LONG_W;

    logic               s3_valid_reg;
    smac_pkg::bar_ctl_t s3_ctl_reg;
    logic [PW-1:0]      short_prod_reg;
    logic [PW-1:0]      long_prod_reg;
    logic               out_en;
    logic               take;

    smac_pkg::rel_t     prev_relation_reg;
    smac_pkg::rel_t     rel_next;
    logic               holding_reg;
    logic               holding_next;
    smac_pkg::sig_t     signal_next;
    smac_pkg::sig_t     signal_reg;
    logic               out_valid_reg;
    logic               in_position_reg;
    logic               warmed_up_reg;
    logic               config_error_reg;

    assign out_en   = !out_valid_reg || out_ready;
    assign s2_ready = !s3_valid_reg || out_en;
    assign take     = s2_valid && s2_ready;

    // short avg vs long avg: short_total * long_count vs long_total * short_count
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            short_prod_reg <= PW'(short_total) * PW'(s2_ctl.long_count);
            long_prod_reg  <= PW'(long_total) * PW'(s2_ctl.short_count);
            s3_ctl_reg     <= s2_ctl;
        end
    end

    always_comb
    begin
        if (short_prod_reg > long_prod_reg)
        begin
            rel_next = smac_pkg::REL_ABOVE;
        end
        else if (short_prod_reg < long_prod_reg)
        begin
            rel_next = smac_pkg::REL_BELOW;
        end
        else
        begin
            rel_next = smac_pkg::REL_EQUAL;
        end

        signal_next  = smac_pkg::SIG_NONE;
        holding_next = holding_reg;
        if (!s3_ctl_reg.bad && s3_ctl_reg.warm)
        begin
            if (prev_relation_reg != smac_pkg::REL_ABOVE && rel_next == smac_pkg::REL_ABOVE)
            begin
                signal_next  = smac_pkg::SIG_BUY;
                holding_next = 1'b1;
            end
            else if (prev_relation_reg != smac_pkg::REL_BELOW &&
                     rel_next == smac_pkg::REL_BELOW)
            begin
                signal_next  = smac_pkg::SIG_SELL;
                holding_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            prev_relation_reg <= smac_pkg::REL_EQUAL;
            holding_reg       <= 1'b0;
        end
        else
        begin
            if (s2_ready)
            begin
                s3_valid_reg <= s2_valid;
            end
            if (out_en)
            begin
                out_valid_reg <= s3_valid_reg;
            end
            if (clear)
            begin
                prev_relation_reg <= smac_pkg::REL_EQUAL;
            end
            else if (s3_valid_reg && out_en && !s3_ctl_reg.bad)
            begin
                prev_relation_reg <= rel_next;
                holding_reg       <= holding_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_valid_reg && out_en)
        begin
            signal_reg       <= signal_next;
            in_position_reg  <= holding_next;
            warmed_up_reg    <= s3_ctl_reg.warm && !s3_ctl_reg.bad;
            config_error_reg <= s3_ctl_reg.bad;
        end
    end

    assign out_valid    = out_valid_reg;
    assign signal       = signal_reg;
    assign in_position  = in_position_reg;
    assign warmed_up    = warmed_up_reg;
    assign config_error = config_error_reg;

    `SMAC_ASSERT(a_buy_sets_position, out_valid_reg && signal_reg == smac_pkg::SIG_BUY |-> in_position_reg, "buy without position")
    `SMAC_ASSERT(a_sell_clears_position, out_valid_reg && signal_reg == smac_pkg::SIG_SELL |-> !in_position_reg, "sell with position held")
    `SMAC_ASSERT(a_cfg_error_quiet, out_valid_reg && config_error_reg |-> signal_reg == smac_pkg::SIG_NONE && !warmed_up_reg, "signal on bad windows")
    `SMAC_ASSERT_NEXT(a_result_lands, s3_valid_reg && out_en, out_valid_reg, "result lost at output")

endmodule

// ===== src/moving_average_crossover_detector_core.sv =====
// ---------------------------------------------------------------------------
// moving_average_crossover_detector_core
// Simple moving average crossover detector, one bar per clock.
// ---------------------------------------------------------------------------
// Takes one close price per bar and returns one result word per bar. A new bar
// is accepted every cycle unless the pipe is backed up; a result word is valid once
// its bar has passed four register stages: ring read, running sums,
// cross-multiply, decision/output register. The input stalls only when all
// four stages hold words and the receiver is not ready. The throughput is set
// by the running-sum update, a loop fed by the price ring's two registered read
// ports and one write port. Until a full long window of bars is seen, signal
// stays none and warmed_up low. Writing either window register clears the
// history (holding is kept) and must be done while idle. Windows with
// short >= long, short of zero, or long outside 2..MAX_WINDOW give
// config_error with no signal and leave all state untouched.
module moving_average_crossover_detector_core #(
    parameter int MAX_WINDOW = smac_pkg::MAX_WINDOW_DEF,
    parameter int PRICE_BITS = smac_pkg::PRICE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write,
    input  logic [0:0]                           cfg_index,
    input  logic [smac_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [smac_pkg::PRICE_IN_W-1:0]      close_price,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           signal,
    output logic                                 in_position,
    output logic                                 warmed_up,
    output logic                                 config_error
);

    localparam int TW = PRICE_BITS + $clog2(MAX_WINDOW);

    logic [smac_pkg::SHORT_W-1:0] short_len_reg;
    logic [smac_pkg::LONG_W-1:0]  long_len_reg;
    logic                         bad;
    logic [PRICE_BITS-1:0]        price;

    logic                         s1_valid;
    logic                         s1_ready;
    smac_pkg::bar_ctl_t           s1_ctl;
    logic [PRICE_BITS-1:0]        s1_price;
    logic [PRICE_BITS-1:0]        s1_old_short;
    logic [PRICE_BITS-1:0]        s1_old_long;
    logic                         s2_valid;
    logic                         s2_ready;
    smac_pkg::bar_ctl_t           s2_ctl;
    logic [TW-1:0]                short_total;
    logic [TW-1:0]                long_total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_len_reg <= smac_pkg::SHORT_RST;
            long_len_reg  <= smac_pkg::LONG_RST;
        end
        else if (cfg_write)
        begin
            unique case (smac_pkg::reg_idx_t'(cfg_index))
                smac_pkg::REG_SHORT: short_len_reg <= cfg_data[smac_pkg::SHORT_W-1:0];
                smac_pkg::REG_LONG:  long_len_reg  <= cfg_data[smac_pkg::LONG_W-1:0];
            endcase
        end
    end

    assign bad = (short_len_reg == '0) || (long_len_reg < 9'd2) ||
                 (int'(long_len_reg) > MAX_WINDOW) ||
                 ({1'b0, short_len_reg} >= long_len_reg);

    assign price = PRICE_BITS'(close_price);

    smac_window #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (cfg_write),
        .short_len    (short_len_reg),
        .long_len     (long_len_reg),
        .bad          (bad),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .price        (price),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1_ctl       (s1_ctl),
        .s1_price     (s1_price),
        .s1_old_short (s1_old_short),
        .s1_old_long  (s1_old_long)
    );

    smac_sums #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_sums (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (cfg_write),
        .s1_valid     (s1_valid),
        .s1_ready     (s1_ready),
        .s1_ctl       (s1_ctl),
        .s1_price     (s1_price),
        .s1_old_short (s1_old_short),
        .s1_old_long  (s1_old_long),
        .s2_valid     (s2_valid),
        .s2_ready     (s2_ready),
        .s2_ctl       (s2_ctl),
        .short_total  (short_total),
        .long_total   (long_total)
    );

    smac_cross #(
        .MAX_WINDOW (MAX_WINDOW),
        .PRICE_BITS (PRICE_BITS)
    ) u_cross (
        .clk          (clk),
        .rst_n        (rst_n),
        .clear        (cfg_write),
        .s2_valid     (s2_valid),
        .s2_ready     (s2_ready),
        .s2_ctl       (s2_ctl),
        .short_total  (short_total),
        .long_total   (long_total),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .signal       (signal),
        .in_position  (in_position),
        .warmed_up    (warmed_up),
        .config_error (config_error)
    );

endmodule

// ===== tb/tb_moving_average_crossover_detector_core.sv =====
// ---------------------------------------------------------------------------
// tb_moving_average_crossover_detector_core
// Checks the crossover detector core against a cycle-free model of its bars.
// A queue-fed driver offers close prices with random gaps. A monitor compares
// every result word with the outcome predicted when its bar was accepted.
// Window settings run from the smallest pair to a full 256-bar ring,
// including unusable ones. A long receiver hold-off backs up the pipe.
// ---------------------------------------------------------------------------
module tb_moving_average_crossover_detector_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int STALL_LIMIT   = 3000;
    localparam int NUM_SETTINGS  = 15;

    typedef struct packed {
        smac_pkg::sig_t signal;
        logic           in_position;
        logic           warmed_up;
        logic           config_error;
    } bar_outcome_t;

    logic                            clk          = 1'b0;
    logic                            rst_n        = 1'b0;
    logic                            cfg_write    = 1'b0;
    logic [0:0]                      cfg_index    = '0;
    logic [smac_pkg::CFG_DATA_W-1:0] cfg_data     = '0;
    logic                            in_valid     = 1'b0;
    logic                            in_ready;
    logic [smac_pkg::PRICE_IN_W-1:0] close_price  = '0;
    logic                            out_valid;
    logic                            out_ready    = 1'b0;
    logic [1:0]                      signal;
    logic                            in_position;
    logic                            warmed_up;
    logic                            config_error;

    // model state
    logic [31:0]                  ring [smac_pkg::MAX_WINDOW_DEF];
    logic [7:0]                   write_slot    = '0;
    logic [8:0]                   bars_seen     = '0;
    logic [63:0]                  short_total   = '0;
    logic [63:0]                  long_total    = '0;
    smac_pkg::rel_t               last_relation = smac_pkg::REL_EQUAL;
    logic                         holding       = 1'b0;
    logic [smac_pkg::SHORT_W-1:0] win_short     = smac_pkg::SHORT_RST;
    logic [smac_pkg::LONG_W-1:0]  win_long      = smac_pkg::LONG_RST;

    logic [31:0]  price_feed [$];
    bar_outcome_t expected_outcomes [$];
    logic [31:0]  walk_level   = '0;
    int           tx_idle_pct  = 7;
    int           rx_idle_pct  = 80;
    logic         hold_req     = 1'b0;
    int           hold_left    = 0;
    int           stall_cycles = 0;
    int           error_count  = 0;

    int plan_short [NUM_SETTINGS] = '{1, 3, 0, 511, 10, 8, 200, 1, 1, 50, 1, -1, 4, -1, 5};
    int plan_long  [NUM_SETTINGS] = '{2, 7, 20, 256, 10, 30, 100, 1, 300, 64, 511, -1, 5, -1, 20};
    int plan_items [NUM_SETTINGS] = '{160, 120, 4, 290, 4, 150, 4, 4, 4, 150, 4, 150, 120, 150,
                                      120};

    moving_average_crossover_detector_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .close_price  (close_price),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .signal       (signal),
        .in_position  (in_position),
        .warmed_up    (warmed_up),
        .config_error (config_error)
    );

    always #4 clk = ~clk;

    function automatic bar_outcome_t predict_bar(input logic [31:0] price);
        bar_outcome_t   res;
        logic [7:0]     old_slot;
        logic [8:0]     n_short;
        logic [63:0]    lhs;
        logic [63:0]    rhs;
        smac_pkg::rel_t rel;
        res = '{signal: smac_pkg::SIG_NONE, in_position: holding, warmed_up: 1'b0,
                config_error: 1'b0};
        if (win_short == 0 || win_long < 2 || win_long > smac_pkg::MAX_WINDOW_DEF
            || win_short >= win_long)
        begin
            res.config_error = 1'b1;
            return res;
        end
        // retire the oldest bar of each full window before the ring slot is reused
        if (bars_seen >= win_short)
        begin
            old_slot = write_slot - win_short;
            short_total -= ring[old_slot];
        end
        if (bars_seen >= win_long)
        begin
            old_slot = write_slot - win_long[7:0];
            long_total -= ring[old_slot];
        end
        short_total += price;
        long_total += price;
        ring[write_slot] = price;
        write_slot++;
        if (bars_seen < win_long)
            bars_seen++;
        n_short = (bars_seen < win_short) ? bars_seen : win_short;
        // short_sum / n_short vs long_sum / bars_seen, cross-multiplied
        lhs = short_total * bars_seen;
        rhs = long_total * n_short;
        if (lhs > rhs)
            rel = smac_pkg::REL_ABOVE;
        else if (lhs < rhs)
            rel = smac_pkg::REL_BELOW;
        else
            rel = smac_pkg::REL_EQUAL;
        if (bars_seen >= win_long)
        begin
            res.warmed_up = 1'b1;
            if (last_relation != smac_pkg::REL_ABOVE && rel == smac_pkg::REL_ABOVE)
            begin
                res.signal = smac_pkg::SIG_BUY;
                holding = 1'b1;
            end
            else if (last_relation != smac_pkg::REL_BELOW && rel == smac_pkg::REL_BELOW)
            begin
                res.signal = smac_pkg::SIG_SELL;
                holding = 1'b0;
            end
        end
        last_relation = rel;
        res.in_position = holding;
        return res;
    endfunction

    // mostly a random walk so the averages actually cross; some full-range noise
    function automatic logic [31:0] next_price();
        int     pick;
        longint step;
        longint lvl;
        pick = $urandom_range(99);
        if (pick < 8)
            return $urandom();
        if (pick < 12)
            return pick[0] ? 32'hFFFF_FFFF : 32'h0;
        step = $urandom_range(32'd1 << $urandom_range(20));
        if ($urandom_range(1) == 1)
            step = -step;
        lvl = longint'(walk_level) + step;
        if (lvl < 0)
            lvl = 0;
        else if (lvl > 64'hFFFF_FFFF)
            lvl = 64'hFFFF_FFFF;
        walk_level = lvl[31:0];
        return walk_level;
    endfunction

    task automatic add_price(input logic [31:0] p);
        price_feed.insert(price_feed.size(), p);
    endtask

    task automatic write_window(input smac_pkg::reg_idx_t idx,
                                input logic [smac_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        if (idx == smac_pkg::REG_SHORT)
            win_short = data[smac_pkg::SHORT_W-1:0];
        else
            win_long = data;
        // history cleared, position kept
        write_slot    = '0;
        bars_seen     = '0;
        short_total   = '0;
        long_total    = '0;
        last_relation = smac_pkg::REL_EQUAL;
    endtask

    task automatic settle_idle();
        do
            @(negedge clk);
        while (price_feed.size() != 0 || in_valid || expected_outcomes.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            close_price <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_outcomes.insert(expected_outcomes.size(), predict_bar(close_price));
            if (!in_valid || in_ready)
            begin
                if (price_feed.size() != 0 && $urandom_range(99) >= tx_idle_pct)
                begin
                    in_valid    <= 1'b1;
                    close_price <= price_feed[0];
                    price_feed.delete(0);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge clk or negedge rst_n)
    begin : rx_side
        bar_outcome_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    $error("result word with no bar pending");
                    error_count++;
                end
                else
                begin
                    want = expected_outcomes[0];
                    expected_outcomes.delete(0);
                    if (signal !== want.signal)
                    begin
                        $error("signal: expected %0d, got %0d", want.signal, signal);
                        error_count++;
                    end
                    if (in_position !== want.in_position)
                    begin
                        $error("in_position: expected %0d, got %0d", want.in_position,
                               in_position);
                        error_count++;
                    end
                    if (warmed_up !== want.warmed_up)
                    begin
                        $error("warmed_up: expected %0d, got %0d", want.warmed_up, warmed_up);
                        error_count++;
                    end
                    if (config_error !== want.config_error)
                    begin
                        $error("config_error: expected %0d, got %0d", want.config_error,
                               config_error);
                        error_count++;
                    end
                end
            end
            if (hold_req)
            begin
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else if (stall_cycles == STALL_LIMIT)
        begin
            $display("moving_average_crossover_detector_core test failed");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        int s_short;
        int s_long;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset windows, partial averages only
        add_price(32'hFFFF_FFFF);
        add_price(32'h0);
        add_price(32'h1234_5678);
        settle_idle();

        // zero short window is unusable
        write_window(smac_pkg::REG_SHORT, 9'd0);
        add_price(32'hA5A5_A5A5);
        settle_idle();

        // smallest pair: flat, buy, sell, equal, repeated buy/sell at extremes
        write_window(smac_pkg::REG_SHORT, 9'd1);
        write_window(smac_pkg::REG_LONG, 9'd2);
        add_price(32'h0);
        add_price(32'h0);
        add_price(32'hFFFF_FFFF);
        add_price(32'h0);
        add_price(32'h0);
        add_price(32'd5);
        add_price(32'd5);
        add_price(32'd5);
        add_price(32'hAAAA_AAAA);
        add_price(32'h5555_5555);
        add_price(32'hFFFF_FFFF);
        add_price(32'hFFFF_FFFF);
        settle_idle();

        for (int k = 0; k < NUM_SETTINGS; k++)
        begin
            if (k == 5)
            begin
                tx_idle_pct = 80;
                rx_idle_pct = 7;
            end
            else if (k == 10)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            s_short = plan_short[k];
            s_long  = plan_long[k];
            if (s_short < 0)
            begin
                s_short = $urandom_range(1, 40);
                s_long  = s_short + $urandom_range(1, 60);
            end
            write_window(smac_pkg::REG_SHORT, s_short[smac_pkg::CFG_DATA_W-1:0]);
            write_window(smac_pkg::REG_LONG, s_long[smac_pkg::CFG_DATA_W-1:0]);
            walk_level = $urandom();
            repeat (plan_items[k]) add_price(next_price());
            if (k == 0)
            begin
                // receiver stalls long enough for the pipe to back up into the input
                @(posedge clk);
                hold_req <= 1'b1;
                @(posedge clk);
                hold_req <= 1'b0;
            end
            settle_idle();
        end

        if (expected_outcomes.size() != 0)
        begin
            $error("%0d result words never arrived", expected_outcomes.size());
            error_count++;
        end
        if (error_count == 0)
            $display("moving_average_crossover_detector_core test passed");
        else
            $display("moving_average_crossover_detector_core test failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/smac_pkg.sv
src/smac_window.sv
src/smac_sums.sv
src/smac_cross.sv
src/moving_average_crossover_detector_core.sv
tb/tb_moving_average_crossover_detector_core.sv
